/* rtl/core/sqsi_pkg.sv */
// shared types and constants of the span quantizer and symbol interner
package sqsi_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COORD_W = 32;
    localparam int BIN_W = 33;
    localparam int HBIN_W = 32;
    localparam int SYM_W = 8;
    localparam int LEN_W = 34;
    localparam int Q_W = 16;
    localparam int NUM_W = 35;
    localparam int DEN_W = 17;
    localparam int ADDR_W = 4;

    localparam logic [ADDR_W-1:0] REG_EDGE_MODE = 4'h0;
    localparam logic [ADDR_W-1:0] REG_WIDTH_Q = 4'h4;
    localparam logic [ADDR_W-1:0] REG_HEIGHT_Q = 4'h8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP_DIV,
        ST_GAP_WAIT,
        ST_GAP_LOOK,
        ST_GAP_LWAIT,
        ST_GAP_OUT,
        ST_W_DIV,
        ST_W_WAIT,
        ST_H_DIV,
        ST_H_WAIT,
        ST_F_LOOK,
        ST_F_LWAIT,
        ST_F_OUT
    } state_t;

    typedef struct packed {
        logic                     valid;
        logic                     is_filled;
        logic signed [BIN_W-1:0]  first_bin;
        logic [HBIN_W-1:0]        second_bin;
        logic signed [SYM_W-1:0]  new_sym;
        logic                     hit;
        logic                     inserted;
        logic signed [SYM_W-1:0]  sym;
    } look_t;

endpackage

/* rtl/core/sqsi_div.sv */
// restoring divider, one quotient bit per cycle
module sqsi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [sqsi_pkg::NUM_W-1:0]    numer,
    input  logic [sqsi_pkg::DEN_W-1:0]    denom,
    output logic                          busy,
    output logic                          done,
    output logic [sqsi_pkg::NUM_W-1:0]    quot
);

    localparam int NW = sqsi_pkg::NUM_W;
    localparam int DW = sqsi_pkg::DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [NW-1:0]     num_reg, num_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     den_reg, den_next;
    logic [DW:0]       trial;
    logic              qbit;

    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        qbit = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
            num_next = numer;
            rem_next = '0;
            den_next = denom;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            num_next = {num_reg[NW-2:0], qbit};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = num_reg;

endmodule

/* rtl/core/sqsi_cell.sv */
// one interner entry; compares or inserts the key passing through
module sqsi_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  sqsi_pkg::look_t     pkt_in,
    output sqsi_pkg::look_t     pkt_out
);

    logic                                   valid_reg;
    logic                                   filled_reg;
    logic signed [sqsi_pkg::BIN_W-1:0]      first_reg;
    logic [sqsi_pkg::HBIN_W-1:0]            second_reg;
    logic signed [sqsi_pkg::SYM_W-1:0]      sym_reg;
    sqsi_pkg::look_t                        pkt_reg, pkt_next;
    logic                                   match;
    logic                                   ins;

    always_comb
    begin
        match = pkt_in.valid && valid_reg && !pkt_in.hit
            && (filled_reg == pkt_in.is_filled)
            && (first_reg == pkt_in.first_bin)
            && (second_reg == pkt_in.second_bin);
        ins = pkt_in.valid && !pkt_in.hit && !valid_reg;
        pkt_next = pkt_in;
        if (match)
        begin
            pkt_next.hit = 1'b1;
            pkt_next.sym = sym_reg;
        end
        else if (ins)
        begin
            pkt_next.hit = 1'b1;
            pkt_next.inserted = 1'b1;
            pkt_next.sym = pkt_in.new_sym;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pkt_reg <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            if (clear)
                valid_reg <= 1'b0;
            else if (ins)
                valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ins)
        begin
            filled_reg <= pkt_in.is_filled;
            first_reg <= pkt_in.first_bin;
            second_reg <= pkt_in.second_bin;
            sym_reg <= pkt_in.new_sym;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

/* rtl/core/span_quantize_symbol_interner.sv */
// top level: span quantizer with a per-slab symbol interner built as a chain of cells
// One span item is taken at a time. A span causes up to two division passes
// (gap and width) plus one more for the height in edge mode, each in the shared
// bit-serial divider, and one interner lookup per token, which walks the key
// through the TABLE_DEPTH cells at one cell a cycle, then loads the output
// register; an item can also wait for the result side to take a token.
// The input is accepted again as soon as the last token is in the output register.
module span_quantize_symbol_interner #(
    parameter int TABLE_DEPTH = sqsi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [95:0]                       s_axis_tdata,  // span_lo, span_hi, span_height
    input  logic                              s_axis_tuser,  // first_of_slab
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // token_start, symbol, quantized_length, table_overflow, zero fill
    output logic [79:0]                       m_axis_tdata,
    output logic                              m_axis_tuser,  // is_gap
    output logic                              m_axis_tlast,  // last_of_run
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sqsi_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int BW = sqsi_pkg::BIN_W;
    localparam int SW = sqsi_pkg::SYM_W;
    localparam int QW = sqsi_pkg::Q_W;

    sqsi_pkg::state_t state_reg, state_next;

    logic                  edge_mode_reg;
    logic [QW-1:0]         width_q_reg;
    logic [QW-1:0]         height_q_reg;
    logic [QW-1:0]         wq, hq;

    logic [31:0]           lo_reg, hi_reg, height_reg, prev_hi_reg;
    logic                  have_prev_reg;
    logic                  first_reg;
    logic signed [BW-1:0]  gbin_reg, wbin_reg;
    logic [31:0]           hbin_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      filled_cnt_reg, gap_cnt_reg;
    logic signed [SW-1:0]  sym_reg;
    logic                  ovf_reg;

    logic                  out_valid_reg;
    logic [31:0]           out_start_reg;
    logic signed [SW-1:0]  out_sym_reg;
    logic [sqsi_pkg::LEN_W-1:0] out_len_reg;
    logic                  out_gap_reg, out_last_reg, out_ovf_reg;

    logic                  accept;
    logic                  out_free;
    logic                  cfg_wr;

    logic                  div_start, div_busy, div_done;
    logic [sqsi_pkg::NUM_W-1:0] div_numer, div_quot;
    logic [sqsi_pkg::DEN_W-1:0] div_denom;
    logic signed [BW-1:0]  div_val;
    logic [BW-1:0]         div_mag;
    logic [QW-1:0]         div_q;
    logic signed [BW-1:0]  q_bin;
    logic                  gap_keep;

    logic                  look_issue;
    logic                  clear_table;
    sqsi_pkg::look_t       look_in;
    sqsi_pkg::look_t       chain [TABLE_DEPTH+1];
    sqsi_pkg::look_t       look_res;
    logic signed [BW-1:0]  len_bin;
    logic signed [BW+QW:0] len_prod;

    assign wq = (width_q_reg == '0) ? QW'(1) : width_q_reg;
    assign hq = (height_q_reg == '0) ? QW'(1) : height_q_reg;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr)
            sqsi_pkg::REG_EDGE_MODE: prdata = {31'd0, edge_mode_reg};
            sqsi_pkg::REG_WIDTH_Q:   prdata = {16'd0, width_q_reg};
            sqsi_pkg::REG_HEIGHT_Q:  prdata = {16'd0, height_q_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_mode_reg <= 1'b0;
            width_q_reg <= QW'(1);
            height_q_reg <= QW'(1);
        end
        else if (cfg_wr)
        begin
            unique case (paddr)
                sqsi_pkg::REG_EDGE_MODE: edge_mode_reg <= pwdata[0];
                sqsi_pkg::REG_WIDTH_Q:   width_q_reg <= pwdata[QW-1:0];
                sqsi_pkg::REG_HEIGHT_Q:  height_q_reg <= pwdata[QW-1:0];
                default: ;
            endcase
        end
    end

    // divider operand selection
    always_comb
    begin
        case (state_reg)
            sqsi_pkg::ST_GAP_DIV:
                div_val = $signed({1'b0, lo_reg}) - $signed({1'b0, prev_hi_reg});
            sqsi_pkg::ST_W_DIV:
                div_val = $signed({1'b0, hi_reg}) - $signed({1'b0, lo_reg});
            default:
                div_val = $signed({1'b0, height_reg});
        endcase
        div_q = (state_reg == sqsi_pkg::ST_H_DIV) ? hq : wq;
        div_mag = div_val[BW-1] ? BW'(-div_val) : BW'(div_val);
        div_numer = {1'b0, div_mag, 1'b0} + sqsi_pkg::NUM_W'(div_q);
        div_denom = {div_q, 1'b0};
        q_bin = neg_reg ? -$signed(div_quot[BW-1:0]) : $signed(div_quot[BW-1:0]);
        gap_keep = !edge_mode_reg || (!neg_reg && (div_quot[BW-1:0] != '0));
    end

    sqsi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    // key into the cell chain
    always_comb
    begin
        look_in = '0;
        look_in.valid = look_issue;
        look_in.is_filled = (state_reg == sqsi_pkg::ST_F_LOOK);
        if (look_in.is_filled)
        begin
            look_in.first_bin = wbin_reg;
            look_in.second_bin = hbin_reg;
            look_in.new_sym = SW'(filled_cnt_reg + 1'b1);
        end
        else
        begin
            look_in.first_bin = gbin_reg;
            look_in.second_bin = '0;
            look_in.new_sym = -SW'(gap_cnt_reg + 1'b1);
        end
    end

    assign chain[0] = look_in;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        sqsi_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .clear   (clear_table),
            .pkt_in  (chain[i]),
            .pkt_out (chain[i+1])
        );
    end

    assign look_res = chain[TABLE_DEPTH];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sqsi_pkg::ST_IDLE:
                if (accept)
                    state_next = (have_prev_reg && !s_axis_tuser) ? sqsi_pkg::ST_GAP_DIV
                                                                  : sqsi_pkg::ST_W_DIV;
            sqsi_pkg::ST_GAP_DIV:   state_next = sqsi_pkg::ST_GAP_WAIT;
            sqsi_pkg::ST_GAP_WAIT:
                if (div_done)
                    state_next = gap_keep ? sqsi_pkg::ST_GAP_LOOK : sqsi_pkg::ST_W_DIV;
            sqsi_pkg::ST_GAP_LOOK:  state_next = sqsi_pkg::ST_GAP_LWAIT;
            sqsi_pkg::ST_GAP_LWAIT:
                if (look_res.valid)
                    state_next = sqsi_pkg::ST_GAP_OUT;
            sqsi_pkg::ST_GAP_OUT:
                if (out_free)
                    state_next = sqsi_pkg::ST_W_DIV;
            sqsi_pkg::ST_W_DIV:     state_next = sqsi_pkg::ST_W_WAIT;
            sqsi_pkg::ST_W_WAIT:
                if (div_done)
                    state_next = edge_mode_reg ? sqsi_pkg::ST_H_DIV : sqsi_pkg::ST_F_LOOK;
            sqsi_pkg::ST_H_DIV:     state_next = sqsi_pkg::ST_H_WAIT;
            sqsi_pkg::ST_H_WAIT:
                if (div_done)
                    state_next = sqsi_pkg::ST_F_LOOK;
            sqsi_pkg::ST_F_LOOK:    state_next = sqsi_pkg::ST_F_LWAIT;
            sqsi_pkg::ST_F_LWAIT:
                if (look_res.valid)
                    state_next = sqsi_pkg::ST_F_OUT;
            sqsi_pkg::ST_F_OUT:
                if (out_free)
                    state_next = sqsi_pkg::ST_IDLE;
            default:                state_next = sqsi_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_axis_tready = (state_reg == sqsi_pkg::ST_IDLE);
        div_start = (state_reg == sqsi_pkg::ST_GAP_DIV) || (state_reg == sqsi_pkg::ST_W_DIV)
                 || (state_reg == sqsi_pkg::ST_H_DIV);
        look_issue = (state_reg == sqsi_pkg::ST_GAP_LOOK) || (state_reg == sqsi_pkg::ST_F_LOOK);
        clear_table = accept && s_axis_tuser;
        len_bin = (state_reg == sqsi_pkg::ST_GAP_OUT) ? gbin_reg : wbin_reg;
        len_prod = len_bin * $signed({1'b0, wq});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sqsi_pkg::ST_IDLE;
            have_prev_reg <= 1'b0;
            prev_hi_reg <= '0;
            filled_cnt_reg <= '0;
            gap_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear_table)
            begin
                have_prev_reg <= 1'b0;
                filled_cnt_reg <= '0;
                gap_cnt_reg <= '0;
            end
            if (look_res.valid && look_res.inserted)
            begin
                if (look_res.is_filled)
                    filled_cnt_reg <= filled_cnt_reg + 1'b1;
                else
                    gap_cnt_reg <= gap_cnt_reg + 1'b1;
            end
            if ((state_reg == sqsi_pkg::ST_GAP_OUT || state_reg == sqsi_pkg::ST_F_OUT)
                && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_axis_tready)
                out_valid_reg <= 1'b0;
            if (state_reg == sqsi_pkg::ST_F_OUT && out_free)
            begin
                prev_hi_reg <= hi_reg;
                have_prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg <= s_axis_tdata[31:0];
            hi_reg <= s_axis_tdata[63:32];
            height_reg <= s_axis_tdata[95:64];
            first_reg <= s_axis_tuser;
        end
        if (div_start)
            neg_reg <= div_val[BW-1];
        if (div_done)
        begin
            case (state_reg)
                sqsi_pkg::ST_GAP_WAIT: gbin_reg <= q_bin;
                sqsi_pkg::ST_W_WAIT:
                begin
                    wbin_reg <= q_bin;
                    hbin_reg <= '0;
                end
                default:               hbin_reg <= div_quot[31:0];
            endcase
        end
        if (look_res.valid)
        begin
            sym_reg <= look_res.hit ? look_res.sym : '0;
            ovf_reg <= !look_res.hit;
        end
        if ((state_reg == sqsi_pkg::ST_GAP_OUT || state_reg == sqsi_pkg::ST_F_OUT) && out_free)
        begin
            out_gap_reg <= (state_reg == sqsi_pkg::ST_GAP_OUT);
            out_last_reg <= (state_reg == sqsi_pkg::ST_F_OUT);
            out_start_reg <= (state_reg == sqsi_pkg::ST_GAP_OUT) ? prev_hi_reg : lo_reg;
            out_sym_reg <= sym_reg;
            out_ovf_reg <= ovf_reg;
            out_len_reg <= len_prod[sqsi_pkg::LEN_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {5'd0, out_ovf_reg, out_len_reg, out_sym_reg, out_start_reg};
    assign m_axis_tuser = out_gap_reg;
    assign m_axis_tlast = out_last_reg;

    a_look_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        look_res.valid |-> (state_reg == sqsi_pkg::ST_GAP_LWAIT
                            || state_reg == sqsi_pkg::ST_F_LWAIT))
        else $error("lookup result outside wait state");

    a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == sqsi_pkg::ST_GAP_WAIT || state_reg == sqsi_pkg::ST_W_WAIT
                      || state_reg == sqsi_pkg::ST_H_WAIT))
        else $error("divider done outside wait state");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_busy)
        else $error("input ready while divider busy");

    a_first_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_axis_tuser) |=> (filled_cnt_reg == '0 && gap_cnt_reg == '0 && first_reg))
        else $error("slab start did not clear interner counts");

endmodule

/* test/tb_span_quantize_symbol_interner.sv */
// testbench of the span quantizer and symbol interner: random and directed spans
`timescale 1ns / 100ps

module tb_span_quantize_symbol_interner;

    localparam int DEPTH = sqsi_pkg::TABLE_DEPTH_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] height;
        logic        first;
    } span_t;

    typedef struct {
        logic [31:0]        start;
        logic signed [7:0]  sym;
        logic signed [33:0] qlen;
        logic               gap;
        logic               last;
        logic               ovf;
    } token_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [sqsi_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    span_quantize_symbol_interner uut (.*);

    always #2 clk = ~clk;

    // predictor state
    logic        p_edge;
    logic [15:0] p_wq;
    logic [15:0] p_hq;
    logic [31:0] p_prev_hi;
    logic        p_have_prev;
    logic               k_filled [DEPTH];
    logic signed [32:0] k_first [DEPTH];
    logic [31:0]        k_second [DEPTH];
    logic signed [7:0]  k_sym [DEPTH];
    int n_used;
    int n_filled;
    int n_gap;

    span_t  pending_spans[$];
    token_t expected_tokens[$];
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int errors;
    int tokens_seen;
    int overflow_seen;
    longint cycles;

    function automatic void queue_span(span_t s);
        pending_spans.insert(pending_spans.size(), s);
    endfunction

    function automatic void queue_token(token_t t);
        expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function automatic logic signed [32:0] round_bins(logic signed [34:0] v, logic [15:0] q);
        logic [34:0] mag;
        logic [34:0] qq;
        logic [34:0] res;
        qq = (q == 0) ? 35'd1 : {19'd0, q};
        mag = v[34] ? -v : v;
        res = (2 * mag + qq) / (2 * qq);
        return v[34] ? -res[32:0] : res[32:0];
    endfunction

    function automatic logic signed [7:0] intern_key(logic filled, logic signed [32:0] a,
                                                     logic [31:0] b, output logic ovf);
        ovf = 1'b0;
        for (int i = 0; i < n_used; i++)
            if (k_filled[i] == filled && k_first[i] == a && k_second[i] == b)
                return k_sym[i];
        if (n_used >= DEPTH)
        begin
            ovf = 1'b1;
            return 8'sd0;
        end
        k_filled[n_used] = filled;
        k_first[n_used] = a;
        k_second[n_used] = b;
        if (filled)
        begin
            n_filled++;
            k_sym[n_used] = 8'(n_filled);
        end
        else
        begin
            n_gap++;
            k_sym[n_used] = -8'(n_gap);
        end
        n_used++;
        return k_sym[n_used - 1];
    endfunction

    function automatic void predict_tokens(span_t s);
        token_t t;
        logic signed [32:0] gb;
        logic signed [32:0] wb;
        logic signed [32:0] hb;
        logic [15:0] wq;
        logic ovf;
        wq = (p_wq == 0) ? 16'd1 : p_wq;
        if (s.first)
        begin
            n_used = 0;
            n_filled = 0;
            n_gap = 0;
            p_have_prev = 1'b0;
        end
        if (p_have_prev)
        begin
            gb = round_bins($signed({3'b000, s.lo}) - $signed({3'b000, p_prev_hi}), wq);
            if (!p_edge || gb > 0)
            begin
                t.sym = intern_key(1'b0, gb, 32'd0, ovf);
                t.start = p_prev_hi;
                t.qlen = 34'(gb * $signed({18'd0, wq}));
                t.gap = 1'b1;
                t.last = 1'b0;
                t.ovf = ovf;
                queue_token(t);
            end
        end
        wb = round_bins($signed({3'b000, s.hi}) - $signed({3'b000, s.lo}), wq);
        hb = p_edge ? round_bins($signed({3'b000, s.height}), p_hq) : 33'sd0;
        t.sym = intern_key(1'b1, wb, hb[31:0], ovf);
        t.start = s.lo;
        t.qlen = 34'(wb * $signed({18'd0, wq}));
        t.gap = 1'b0;
        t.last = 1'b1;
        t.ovf = ovf;
        queue_token(t);
        p_prev_hi = s.hi;
        p_have_prev = 1'b1;
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (s_axis_tvalid)
                    predict_tokens(pending_spans.pop_front());
                if (pending_spans.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_spans[0].height, pending_spans[0].hi,
                                     pending_spans[0].lo};
                    s_axis_tuser <= pending_spans[0].first;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        token_t e;
        if (rst_n)
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout at %0t", $time);
                $display("** span_quantize_symbol_interner: FAILED **");
                $finish;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                tokens_seen++;
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected item %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    e = expected_tokens.pop_front();
                    if (e.ovf)
                        overflow_seen++;
                    if (m_axis_tdata[31:0] !== e.start || m_axis_tdata[39:32] !== e.sym
                        || m_axis_tdata[73:40] !== e.qlen || m_axis_tdata[74] !== e.ovf
                        || m_axis_tuser !== e.gap || m_axis_tlast !== e.last)
                    begin
                        $display("%0t: expected start %h sym %0d len %0d ovf %b gap %b last %b",
                                 $time, e.start, e.sym, e.qlen, e.ovf, e.gap, e.last);
                        $display("%0t: actual   start %h sym %0d len %0d ovf %b gap %b last %b",
                                 $time, m_axis_tdata[31:0], $signed(m_axis_tdata[39:32]),
                                 $signed(m_axis_tdata[73:40]), m_axis_tdata[74],
                                 m_axis_tuser, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [sqsi_pkg::ADDR_W-1:0] addr, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == sqsi_pkg::REG_EDGE_MODE)
            p_edge = value[0];
        else if (addr == sqsi_pkg::REG_WIDTH_Q)
            p_wq = value[15:0];
        else
            p_hq = value[15:0];
    endtask

    task automatic drain();
        wait (pending_spans.size() == 0 && !s_axis_tvalid && expected_tokens.size() == 0);
        repeat (300) @(posedge clk);
    endtask

    function automatic span_t rand_span(logic first, int scale);
        span_t s;
        logic [31:0] base;
        base = (p_have_prev && $urandom_range(9) != 0) ? p_prev_hi : $urandom;
        s.first = first;
        case ($urandom_range(9))
            0: s.lo = $urandom;
            1: s.lo = base - $urandom_range(scale);
            default: s.lo = base + $urandom_range(scale);
        endcase
        case ($urandom_range(9))
            0: s.hi = $urandom;
            1: s.hi = s.lo - $urandom_range(scale);
            default: s.hi = s.lo + $urandom_range(scale);
        endcase
        s.height = ($urandom_range(7) == 0) ? $urandom : $urandom_range(scale);
        return s;
    endfunction

    task automatic random_phase(int count, int scale);
        span_t s;
        logic last_hi_known;
        logic [31:0] shadow_hi;
        int slab_left;
        slab_left = 0;
        last_hi_known = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            s = rand_span(slab_left == 0, scale);
            if (last_hi_known && $urandom_range(9) != 0)
            begin
                s.lo = shadow_hi + $urandom_range(scale);
                s.hi = s.lo + $urandom_range(scale);
            end
            slab_left = (slab_left == 0) ? $urandom_range(90, 2) : slab_left - 1;
            shadow_hi = s.hi;
            last_hi_known = 1'b1;
            queue_span(s);
        end
        drain();
    endtask

    initial
    begin
        span_t s;
        p_edge = 1'b0;
        p_wq = 16'd1;
        p_hq = 16'd1;
        p_prev_hi = '0;
        p_have_prev = 1'b0;
        n_used = 0;
        n_filled = 0;
        n_gap = 0;
        errors = 0;
        tokens_seen = 0;
        overflow_seen = 0;
        cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 23;
        recv_idle_pct = 63;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // no previous span, then field extremes, reversed and overlapping spans
        queue_span('{32'd10, 32'd20, 32'd5, 1'b0});
        queue_span('{32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
        queue_span('{32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0});
        queue_span('{32'd0, 32'd0, 32'd0, 1'b0});
        queue_span('{32'd100, 32'd50, 32'd7, 1'b0});
        queue_span('{32'd40, 32'd60, 32'd7, 1'b1});
        queue_span('{32'd55, 32'd70, 32'd7, 1'b0});
        queue_span('{32'd90, 32'd110, 32'd9, 1'b0});
        drain();
        write_reg(sqsi_pkg::REG_WIDTH_Q, 32'd4);
        write_reg(sqsi_pkg::REG_EDGE_MODE, 32'd1);
        write_reg(sqsi_pkg::REG_HEIGHT_Q, 32'd4);
        // ties, dropped non-positive gaps in edge mode
        queue_span('{32'd0, 32'd6, 32'd2, 1'b1});
        queue_span('{32'd2, 32'd8, 32'd6, 1'b0});
        queue_span('{32'd9, 32'd15, 32'd10, 1'b0});
        queue_span('{32'd25, 32'd27, 32'hFFFF_FFFF, 1'b0});
        queue_span('{32'd10, 32'd5, 32'd1, 1'b0});
        drain();
        // zero quantum acts as one; mode change mid-slab
        write_reg(sqsi_pkg::REG_WIDTH_Q, 32'd0);
        write_reg(sqsi_pkg::REG_HEIGHT_Q, 32'd0);
        queue_span('{32'd100, 32'd103, 32'd3, 1'b0});
        drain();
        write_reg(sqsi_pkg::REG_EDGE_MODE, 32'd0);
        write_reg(sqsi_pkg::REG_WIDTH_Q, 32'd65535);
        queue_span('{32'd200, 32'd40000, 32'd3, 1'b0});
        queue_span('{32'hFFFF_0000, 32'h0000_1000, 32'd3, 1'b0});
        drain();
        write_reg(sqsi_pkg::REG_WIDTH_Q, 32'd1);
        // overflow the table with distinct widths in one slab
        for (int i = 0; i < 75; i++)
        begin
            s.first = (i == 0);
            s.lo = i * 1000;
            s.hi = i * 1000 + i + 1;
            s.height = i;
            queue_span(s);
        end
        // hold off the receiver so the block backs up
        hold_cycles = 3000;
        drain();

        random_phase(450, 40);
        send_idle_pct = 63;
        recv_idle_pct = 23;
        write_reg(sqsi_pkg::REG_EDGE_MODE, 32'd1);
        write_reg(sqsi_pkg::REG_WIDTH_Q, 32'd3);
        write_reg(sqsi_pkg::REG_HEIGHT_Q, 32'd65535);
        random_phase(300, 60);
        write_reg(sqsi_pkg::REG_HEIGHT_Q, 32'd2);
        random_phase(150, 30);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(sqsi_pkg::REG_EDGE_MODE, 32'd0);
        write_reg(sqsi_pkg::REG_WIDTH_Q, 32'd7);
        random_phase(250, 200);
        write_reg(sqsi_pkg::REG_EDGE_MODE, 32'd1);
        write_reg(sqsi_pkg::REG_WIDTH_Q, 32'd1);
        write_reg(sqsi_pkg::REG_HEIGHT_Q, 32'd1);
        random_phase(150, 20);

        $display("covered %0d tokens over both modes, quanta 0..65535, %0d table overflows",
                 tokens_seen, overflow_seen);
        if (errors == 0)
            $display("** span_quantize_symbol_interner: PASSED **");
        else
            $display("** span_quantize_symbol_interner: FAILED **");
        $finish;
    end
endmodule

/* files.f */
rtl/core/sqsi_pkg.sv
rtl/core/sqsi_div.sv
rtl/core/sqsi_cell.sv
rtl/core/span_quantize_symbol_interner.sv
test/tb_span_quantize_symbol_interner.sv
